// ===== hw/rtl/fnpll_pkg.sv =====
// Shared types, constants and helper functions of the PLL register word calculator.
package fnpll_pkg;

  localparam int unsigned FreqW    = 16;
  localparam int unsigned ProdW    = 17;
  localparam int unsigned IntW     = 8;
  localparam int unsigned RemW     = 8;
  localparam int unsigned FracW    = 10;
  localparam int unsigned ModW     = 10;
  localparam int unsigned CodeW    = 3;
  localparam int unsigned WordW    = 32;
  localparam int unsigned ExpW     = 2;
  localparam int unsigned NumWords = 4;
  localparam int unsigned IdxW     = $clog2(NumWords);

  localparam logic [FreqW-1:0] FreqMin = 16'd350;
  localparam logic [FreqW-1:0] FreqMax = 16'd44000;
  localparam int unsigned      VcoLowMhz = 2200;
  localparam int unsigned      DivSteps  = 6;

  localparam int unsigned      PfdTenths = 250;
  localparam int unsigned      RecipShift = 25;
  localparam int unsigned      RecipW    = 18;
  localparam logic [RecipW-1:0] Recip250 =
    RecipW'((64'd1 << RecipShift) / PfdTenths + 64'd1);

  localparam logic [WordW-1:0] WordRfOff  = 32'h00EC_801C;
  localparam logic [WordW-1:0] WordR1Base = 32'h0000_8001;
  localparam logic [WordW-1:0] WordR4Base = 32'h008C_803C;

  localparam logic [IdxW-1:0] IdxRfOff  = 2'd0;
  localparam logic [IdxW-1:0] IdxIntFrc = 2'd1;
  localparam logic [IdxW-1:0] IdxMod    = 2'd2;
  localparam logic [IdxW-1:0] IdxDivSel = 2'd3;

  typedef struct packed {
    logic [IntW-1:0]  int_part;
    logic [RemW-1:0]  rem;
    logic [CodeW-1:0] code;
  } fnpll_front_t;

  typedef struct packed {
    logic [IntW-1:0]  int_part;
    logic [FracW-1:0] frac;
    logic [ModW-1:0]  modulus;
    logic [CodeW-1:0] code;
  } fnpll_words_t;

  // Lowest frequency, in tenths of MHz, whose whole-MHz part reaches the VCO floor at 2^j
  function automatic logic [FreqW-1:0] k_thresh(input int unsigned j);
    int unsigned c;
    c = (VcoLowMhz + (1 << j) - 1) >> j;
    return FreqW'(10 * c);
  endfunction

  function automatic logic [RemW-1:0] div5(input logic [RemW-1:0] x);
    logic [17:0] p;
    p = {10'd0, x} * 18'd205;
    return RemW'(p[17:10]);
  endfunction

  function automatic logic [ModW-1:0] mod_base(input logic [ExpW-1:0] a);
    logic [ModW-1:0] m;
    case (a)
      2'd0:    m = 10'd1000;
      2'd1:    m = 10'd200;
      2'd2:    m = 10'd40;
      default: m = 10'd8;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/fractional_n_pll_register_calc.sv =====
// Top level of the fractional-N PLL register word calculator.
// Each frequency request (tenths of MHz, clamped to 35.0..4400.0 MHz) yields four
// 32-bit register words: RF off, INT/FRAC, modulus, divider select; tlast marks the
// fourth. A request passes the front and reduction pipelines and the output register
// before its first word appears. The output stage sends one word per cycle while m_axis_tready
// is high; a request is taken only while the output stage is empty or sends its fourth word,
// and the six-stage arithmetic pipeline in front of it holds up to six further requests while the output side stalls.
module fractional_n_pll_register_calc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] freq_tenths_mhz
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] reg_word
  output logic        m_axis_tlast    // last_word
);
  import fnpll_pkg::*;

  logic         en;
  logic         front_v, red_v;
  fnpll_front_t front_d;
  fnpll_words_t red_d;

  fnpll_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .freq_i  (s_axis_tdata[FreqW-1:0]),
    .valid_o (front_v),
    .data_o  (front_d)
  );

  fnpll_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_v),
    .data_i  (front_d),
    .valid_o (red_v),
    .data_o  (red_d)
  );

  fnpll_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (red_v),
    .data_i        (red_d),
    .en_o          (en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  assign s_axis_tready = en;

endmodule

// ===== hw/rtl/fnpll_front.sv =====
// Front pipeline: clamp, divider select, VCO product, integer part and remainder.
module fnpll_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [fnpll_pkg::FreqW-1:0] freq_i,
  output logic                        valid_o,
  output fnpll_pkg::fnpll_front_t     data_o
);
  import fnpll_pkg::*;

  logic             v1_q, v2_q, v3_q;
  logic [FreqW-1:0] f1_d, f1_q;
  logic [CodeW-1:0] k1_d, k1_q, k2_q;
  logic [ProdW-1:0] prod2_d, prod2_q;
  logic [IntW-1:0]  q2_d, q2_q;
  logic [ProdW+RecipW-1:0] mul2;
  logic [ProdW-1:0] rem3_w;
  fnpll_front_t     s3_d, s3_q;

  always_comb begin
    f1_d = freq_i;
    if (freq_i < FreqMin) f1_d = FreqMin;
    if (freq_i > FreqMax) f1_d = FreqMax;
    k1_d = '0;
    for (int j = 0; j < DivSteps; j++) begin
      if (f1_d < k_thresh(j)) k1_d = k1_d + CodeW'(1);
    end
  end

  always_comb begin
    prod2_d = ProdW'({1'b0, f1_q}) << k1_q;
    mul2    = {{RecipW{1'b0}}, prod2_d} * {{ProdW{1'b0}}, Recip250};
    q2_d    = mul2[RecipShift+IntW-1:RecipShift];
  end

  always_comb begin
    rem3_w        = prod2_q - ProdW'(q2_q * ProdW'(PfdTenths));
    s3_d.int_part = q2_q;
    s3_d.rem      = rem3_w[RemW-1:0];
    s3_d.code     = k2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q    <= f1_d;
      k1_q    <= k1_d;
      prod2_q <= prod2_d;
      q2_q    <= q2_d;
      k2_q    <= k1_q;
      s3_q    <= s3_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = s3_q;

endmodule

// ===== hw/rtl/fnpll_reduce.sv =====
// Fraction reduction pipeline: three divide-by-five stages, then the power-of-two step.
module fnpll_reduce (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  fnpll_pkg::fnpll_front_t data_i,
  output logic                    valid_o,
  output fnpll_pkg::fnpll_words_t data_o
);
  import fnpll_pkg::*;

  localparam int unsigned Steps = 3;

  logic [Steps-1:0] v_q;
  logic [RemW-1:0]  x_d [Steps];
  logic [RemW-1:0]  x_q [Steps];
  logic [ExpW-1:0]  a_d [Steps];
  logic [ExpW-1:0]  a_q [Steps];
  logic [IntW-1:0]  int_q  [Steps];
  logic [CodeW-1:0] code_q [Steps];
  logic [RemW-1:0]  x_in  [Steps];
  logic [ExpW-1:0]  a_in  [Steps];
  logic [RemW-1:0]  q5    [Steps];

  logic [FracW-1:0] frac5;
  logic [1:0]       b;

  always_comb begin
    for (int s = 0; s < Steps; s++) begin
      x_in[s] = (s == 0) ? data_i.rem : x_q[(s == 0) ? 0 : s-1];
      a_in[s] = (s == 0) ? '0 : a_q[(s == 0) ? 0 : s-1];
      q5[s]   = div5(x_in[s]);
      if (RemW'(q5[s] * RemW'(5)) == x_in[s]) begin
        x_d[s] = q5[s];
        a_d[s] = a_in[s] + ExpW'(1);
      end else begin
        x_d[s] = x_in[s];
        a_d[s] = a_in[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Steps-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Steps; s++) begin
        x_q[s]    <= x_d[s];
        a_q[s]    <= a_d[s];
        int_q[s]  <= (s == 0) ? data_i.int_part : int_q[(s == 0) ? 0 : s-1];
        code_q[s] <= (s == 0) ? data_i.code : code_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  always_comb begin
    frac5 = {x_q[Steps-1], 2'b00};
    if (frac5 == '0 || frac5[2:0] == 3'b000) begin
      b = 2'd3;
    end else if (frac5[1:0] == 2'b00) begin
      b = 2'd2;
    end else if (frac5[0] == 1'b0) begin
      b = 2'd1;
    end else begin
      b = 2'd0;
    end
    data_o.int_part = int_q[Steps-1];
    data_o.frac     = frac5 >> b;
    data_o.modulus  = mod_base(a_q[Steps-1]) >> b;
    data_o.code     = code_q[Steps-1];
  end

  assign valid_o = v_q[Steps-1];

endmodule

// ===== hw/rtl/fnpll_ser.sv =====
// Output stage: hold one result set and send its four register words in order.
module fnpll_ser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  fnpll_pkg::fnpll_words_t     data_i,
  output logic                        en_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [fnpll_pkg::WordW-1:0] m_axis_tdata,
  output logic                        m_axis_tlast
);
  import fnpll_pkg::*;

  logic            v_q;
  logic [IdxW-1:0] idx_d, idx_q;
  fnpll_words_t    w_q;
  logic            fire;

  assign fire = v_q && m_axis_tready;
  assign en_o = !v_q || (fire && idx_q == IdxDivSel);

  always_comb begin
    idx_d = idx_q;
    if (fire) idx_d = idx_q + IdxW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      idx_q <= IdxRfOff;
    end else begin
      idx_q <= idx_d;
      if (en_o) v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) w_q <= data_i;
  end

  always_comb begin
    case (idx_q)
      IdxRfOff:  m_axis_tdata = WordRfOff;
      IdxIntFrc: m_axis_tdata = (WordW'(w_q.int_part) << 15) + (WordW'(w_q.frac) << 3);
      IdxMod:    m_axis_tdata = WordR1Base + (WordW'(w_q.modulus) << 3);
      IdxDivSel: m_axis_tdata = WordR4Base + (WordW'(w_q.code) << 20);
      default:   m_axis_tdata = WordRfOff;
    endcase
  end

  assign m_axis_tvalid = v_q;
  assign m_axis_tlast  = (idx_q == IdxDivSel);

endmodule

// ===== sim/fractional_n_pll_register_calc_tb.sv =====
// Testbench that checks the four PLL register words produced for each frequency request.
module fractional_n_pll_register_calc_tb;

  localparam int unsigned FreqLo      = 350;
  localparam int unsigned FreqHi      = 44000;
  localparam int unsigned VcoLo       = 2200;
  localparam int unsigned VcoHi       = 4400;
  localparam int unsigned DivTries    = 10;
  localparam int unsigned DivCodeWrap = 7;
  localparam int unsigned PfdTenths   = 250;
  localparam int unsigned FullModulus = 1000;
  localparam logic [31:0] RfOffWord   = 32'h00EC_801C;
  localparam logic [31:0] ModBase     = 32'h0000_8001;
  localparam logic [31:0] DivSelBase  = 32'h008C_803C;
  localparam int          NumDirected = 24;
  localparam int          NumRandom   = 480;
  localparam int          IdleLimit   = 3000;
  localparam int          DrainCycles = 20;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } reg_word_t;

  typedef struct packed {
    logic [15:0] freq;
    logic        known;
    logic [31:0] int_frac_word;
    logic [31:0] mod_word;
    logic [31:0] div_word;
  } freq_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  reg_word_t   pending_words[$];
  reg_word_t   head_word;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned rx_phase = 0;
  int unsigned rx_mode = 0;

  fractional_n_pll_register_calc uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic freq_row_t freq_row(input int idx);
    freq_row_t r;
    r = '0;
    case (idx)
      0:  r = '{16'd0,     1'b1, 32'h002C_8018, 32'h0000_8029, 32'h00EC_803C};
      1:  r = '{16'd349,   1'b1, 32'h002C_8018, 32'h0000_8029, 32'h00EC_803C};
      2:  r = '{16'd350,   1'b1, 32'h002C_8018, 32'h0000_8029, 32'h00EC_803C};
      3:  r = '{16'd65535, 1'b1, 32'h0058_0000, 32'h0000_8009, 32'h008C_803C};
      4:  r = '{16'd44000, 1'b1, 32'h0058_0000, 32'h0000_8009, 32'h008C_803C};
      5:  r = '{16'd44001, 1'b1, 32'h0058_0000, 32'h0000_8009, 32'h008C_803C};
      6:  r.freq = 16'd351;
      7:  r.freq = 16'd43999;
      8:  r.freq = 16'd21999;
      9:  r.freq = 16'd22000;
      10: r.freq = 16'd22009;
      11: r.freq = 16'd10999;
      12: r.freq = 16'd11000;
      13: r.freq = 16'd5500;
      14: r.freq = 16'd2750;
      15: r.freq = 16'd1375;
      16: r.freq = 16'd700;
      17: r.freq = 16'd1250;
      18: r.freq = 16'd25000;
      19: r.freq = 16'd25001;
      20: r.freq = 16'd32768;
      21: r.freq = 16'd21845;
      22: r.freq = 16'd43690;
      default: r.freq = 16'd1;
    endcase
    return r;
  endfunction

  task automatic predict_reg_words(input logic [15:0] req);
    int unsigned f;
    int unsigned whole;
    int unsigned mult;
    int unsigned code;
    int unsigned prod;
    int unsigned int_part;
    int unsigned frac;
    int unsigned modulus;
    int unsigned i;
    logic        found;
    logic [31:0] int_frac_word;
    f = 32'(req);
    if (f < FreqLo) f = FreqLo;
    if (f > FreqHi) f = FreqHi;
    whole = f / 10;
    mult  = 1;
    code  = 0;
    found = 1'b0;
    for (i = 0; i < DivTries && !found; i++) begin
      if (whole * mult >= VcoLo && whole * mult <= VcoHi) begin
        found = 1'b1;
      end else begin
        code++;
        mult = mult << 1;
      end
    end
    prod     = f * mult;
    int_part = prod / PfdTenths;
    frac     = (4 * prod) % FullModulus;
    modulus  = FullModulus;
    while (frac % 5 == 0 && modulus % 5 == 0) begin
      frac    = frac / 5;
      modulus = modulus / 5;
    end
    while (frac % 2 == 0 && modulus % 2 == 0) begin
      frac    = frac / 2;
      modulus = modulus / 2;
    end
    code = code % DivCodeWrap;
    int_frac_word = ((int_part & 32'hFFFF) << 15) + ((frac & 32'hFFF) << 3);
    pending_words.push_back('{RfOffWord, 1'b0});
    pending_words.push_back('{int_frac_word, 1'b0});
    pending_words.push_back('{ModBase + ((modulus & 32'hFFF) << 3), 1'b0});
    pending_words.push_back('{DivSelBase + (code << 20), 1'b1});
  endtask

  task automatic send_freq(input freq_row_t r);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.freq;
    do @(posedge clk_i); while (!s_axis_tready);
    if (r.known) begin
      pending_words.push_back('{RfOffWord, 1'b0});
      pending_words.push_back('{r.int_frac_word, 1'b0});
      pending_words.push_back('{r.mod_word, 1'b0});
      pending_words.push_back('{r.div_word, 1'b1});
    end else begin
      predict_reg_words(r.freq);
    end
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_words.size() != 0);
  endtask

  task automatic log_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  always @(negedge clk_i) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase[6:0] == 7'd0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= (rx_phase % 5 == 0);
      default: m_axis_tready <= (rx_phase[4:3] != 2'b11);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        log_mismatch("unexpected word", 32'd0, m_axis_tdata);
      end else begin
        head_word = pending_words.pop_front();
        if (m_axis_tdata !== head_word.word) log_mismatch("reg_word", head_word.word, m_axis_tdata);
        if (m_axis_tlast !== head_word.last) begin
          log_mismatch("last_word", {31'd0, head_word.last}, {31'd0, m_axis_tlast});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    freq_row_t r;
    int        n;
    int        sel;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (n = 0; n < NumDirected; n++) begin
      send_freq(freq_row(n));
    end
    hold_until_drained();
    for (n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) hold_until_drained();
      r   = '0;
      sel = $urandom_range(0, 9);
      if (sel == 0) r.freq = 16'($urandom_range(0, FreqLo - 1));
      else if (sel == 1) r.freq = 16'($urandom_range(FreqHi + 1, 65535));
      else r.freq = 16'($urandom_range(FreqLo, FreqHi));
      send_freq(r);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fnpll_pkg.sv
hw/rtl/fnpll_front.sv
hw/rtl/fnpll_reduce.sv
hw/rtl/fnpll_ser.sv
hw/rtl/fractional_n_pll_register_calc.sv
sim/fractional_n_pll_register_calc_tb.sv
